>>> design/ild_pkg.sv
package ild_pkg;

    localparam int unsigned MAX_INSTR_LEN = 15;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       restart;
    } ild_in_t;

    typedef struct packed {
        logic [3:0] instr_length;
        logic       two_byte_map;
        logic       over_length;
    } ild_out_t;

    typedef enum logic [2:0] {
        PH_OPC,
        PH_ESC,
        PH_MODRM,
        PH_TEST,
        PH_SIB,
        PH_TAIL
    } ild_phase_t;

    // opcode classes held in the lookup tables
    localparam logic [3:0] CLS_PLAIN    = 4'd0;
    localparam logic [3:0] CLS_OPSIZE   = 4'd1;
    localparam logic [3:0] CLS_PREFIX   = 4'd2;
    localparam logic [3:0] CLS_IMM1     = 4'd3;
    localparam logic [3:0] CLS_IMMV     = 4'd4;
    localparam logic [3:0] CLS_IMM2V    = 4'd5;
    localparam logic [3:0] CLS_MRM_IMM1 = 4'd6;
    localparam logic [3:0] CLS_MRM_IMMV = 4'd7;
    localparam logic [3:0] CLS_MRM      = 4'd8;
    localparam logic [3:0] CLS_IMM2     = 4'd9;
    localparam logic [3:0] CLS_IMM3     = 4'd10;
    localparam logic [3:0] CLS_TEST     = 4'd11;
    localparam logic [3:0] CLS_ESCAPE   = 4'd12;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_DISP32  = 3'd5;

    localparam logic [3:0] MAP_ONE [0:255] = '{
        4'd8,4'd8,4'd8,4'd8,4'd3,4'd4,4'd0,4'd0,4'd8,4'd8,4'd8,4'd8,4'd3,4'd4,4'd0,4'd12,
        4'd8,4'd8,4'd8,4'd8,4'd3,4'd4,4'd0,4'd0,4'd8,4'd8,4'd8,4'd8,4'd3,4'd4,4'd0,4'd0,
        4'd8,4'd8,4'd8,4'd8,4'd3,4'd4,4'd2,4'd0,4'd8,4'd8,4'd8,4'd8,4'd3,4'd4,4'd2,4'd0,
        4'd8,4'd8,4'd8,4'd8,4'd3,4'd4,4'd2,4'd0,4'd8,4'd8,4'd8,4'd8,4'd3,4'd4,4'd2,4'd0,
        4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
        4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
        4'd0,4'd0,4'd0,4'd8,4'd2,4'd2,4'd1,4'd2,4'd4,4'd7,4'd3,4'd6,4'd0,4'd0,4'd0,4'd0,
        4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,
        4'd6,4'd7,4'd6,4'd6,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd5,4'd2,4'd0,4'd0,4'd0,4'd0,
        4'd3,4'd4,4'd3,4'd4,4'd0,4'd0,4'd0,4'd0,4'd3,4'd4,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
        4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,
        4'd6,4'd6,4'd9,4'd0,4'd8,4'd8,4'd6,4'd7,4'd10,4'd0,4'd3,4'd0,4'd0,4'd3,4'd0,4'd0,
        4'd8,4'd8,4'd8,4'd8,4'd3,4'd3,4'd0,4'd0,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd3,4'd4,4'd4,4'd5,4'd3,4'd0,4'd0,4'd0,4'd0,
        4'd2,4'd0,4'd2,4'd2,4'd0,4'd0,4'd11,4'd11,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd8,4'd8
    };

    localparam logic [3:0] MAP_ESC [0:255] = '{
        4'd8,4'd8,4'd8,4'd8,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd0,4'd8,4'd0,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd6,4'd6,4'd6,4'd6,4'd8,4'd8,4'd8,4'd0,4'd0,4'd0,4'd0,4'd0,4'd8,4'd8,4'd8,4'd8,
        4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,4'd4,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd0,4'd0,4'd0,4'd8,4'd6,4'd8,4'd0,4'd0,4'd0,4'd0,4'd0,4'd8,4'd6,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd0,4'd0,4'd6,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd6,4'd8,4'd6,4'd6,4'd6,4'd8,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,4'd0,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,
        4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd8,4'd0
    };

endpackage

>>> design/x86_instruction_length_decoder_top.sv
// channel  valid      ready      word       type       carries
// code     code_valid code_ready code_word  ild_in_t   one code byte and restart flag
// len      len_valid  len_ready  len_word   ild_out_t  length of an instruction on its last byte
// cfg      cfg_valid  cfg_ready  cfg_data   1 bit      default operand size, 1 = 16 bit
//
// each byte is decoded while held in the input register; the result of its last byte is
// registered into len_word, and one byte is taken every cycle while len is not stalled
// the decode step is the only loop: the byte state registers update on each processed byte
// a stalled len channel holds the decode stage, which then backs up into code_ready
// rst_n clears all control state and the operand size register; cfg_ready is always high
module x86_instruction_length_decoder_top
    import ild_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     code_valid,
    output logic     code_ready,
    input  ild_in_t  code_word,
    output logic     len_valid,
    input  logic     len_ready,
    output ild_out_t len_word,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    logic       cfg_op16_reg;
    logic       in_valid_reg;
    ild_in_t    in_word_reg;
    logic       len_valid_reg;
    ild_out_t   len_word_reg;

    ild_phase_t phase_reg, phase_next;
    logic [3:0] byte_count_reg, byte_count_next;
    logic [3:0] bytes_rem_reg, bytes_rem_next;
    logic [2:0] pend_imm_reg, pend_imm_next;
    logic       op16_reg, op16_next;
    logic       esc_seen_reg, esc_seen_next;
    logic       low_bit_reg, low_bit_next;
    logic [1:0] mod_reg, mod_next;

    logic       process;
    logic       done;
    logic       over;
    logic       emit;

    assign cfg_ready  = 1'b1;
    assign process    = in_valid_reg && (!len_valid_reg || len_ready);
    assign code_ready = !in_valid_reg || process;
    assign len_valid  = len_valid_reg;
    assign len_word   = len_word_reg;

    always_comb
    begin
        logic       start;
        logic [7:0] b;
        logic [3:0] cls;
        logic [2:0] sz;
        logic [1:0] mod_f;
        logic [2:0] rm_f;
        logic       do_dispatch;
        logic       skip_en;
        logic [3:0] skip_n;
        logic [3:0] disp;

        b     = in_word_reg.code_byte;
        mod_f = b[7:6];
        rm_f  = b[2:0];
        start = in_word_reg.restart || (byte_count_reg == 4'd0);

        if (start)
        begin
            phase_next      = PH_OPC;
            byte_count_next = 4'd0;
            bytes_rem_next  = 4'd0;
            pend_imm_next   = 3'd0;
            op16_next       = cfg_op16_reg;
            esc_seen_next   = 1'b0;
            low_bit_next    = 1'b0;
            mod_next        = 2'd0;
        end
        else
        begin
            phase_next      = phase_reg;
            byte_count_next = byte_count_reg;
            bytes_rem_next  = bytes_rem_reg;
            pend_imm_next   = pend_imm_reg;
            op16_next       = op16_reg;
            esc_seen_next   = esc_seen_reg;
            low_bit_next    = low_bit_reg;
            mod_next        = mod_reg;
        end
        byte_count_next = byte_count_next + 4'd1;

        sz          = op16_next ? 3'd2 : 3'd4;
        cls         = (phase_next == PH_ESC) ? MAP_ESC[b] : MAP_ONE[b];
        do_dispatch = 1'b0;
        skip_en     = 1'b0;
        skip_n      = 4'd0;
        disp        = 4'd0;
        done        = 1'b0;

        unique case (phase_next)
            PH_ESC:
            begin
                esc_seen_next = 1'b1;
                do_dispatch   = 1'b1;
            end
            PH_MODRM, PH_TEST:
            begin
                // test group: immediate only when the reg field is zero
                if (phase_next == PH_TEST && b[5:3] == 3'd0)
                begin
                    pend_imm_next = low_bit_next ? sz : 3'd1;
                end
                if (mod_f == MOD_REG)
                begin
                    skip_en = 1'b1;
                    skip_n  = {1'b0, pend_imm_next};
                end
                else if (rm_f == RM_SIB)
                begin
                    mod_next   = mod_f;
                    phase_next = PH_SIB;
                end
                else
                begin
                    if (mod_f == MOD_NODISP)
                    begin
                        disp = (rm_f == RM_DISP32) ? 4'd4 : 4'd0;
                    end
                    else
                    begin
                        disp = (mod_f == MOD_DISP8) ? 4'd1 : 4'd4;
                    end
                    skip_en = 1'b1;
                    skip_n  = disp + {1'b0, pend_imm_next};
                end
            end
            PH_SIB:
            begin
                if (rm_f == RM_DISP32)
                begin
                    disp = (mod_next == MOD_DISP8) ? 4'd1 : 4'd4;
                end
                else if (mod_next == MOD_NODISP)
                begin
                    disp = 4'd0;
                end
                else
                begin
                    disp = (mod_next == MOD_DISP8) ? 4'd1 : 4'd4;
                end
                skip_en = 1'b1;
                skip_n  = disp + {1'b0, pend_imm_next};
            end
            PH_TAIL:
            begin
                if (bytes_rem_next != 4'd0)
                begin
                    bytes_rem_next = bytes_rem_next - 4'd1;
                end
                done = (bytes_rem_next == 4'd0);
            end
            default:
            begin
                do_dispatch = 1'b1;
            end
        endcase

        if (do_dispatch)
        begin
            unique case (cls)
                CLS_OPSIZE:
                begin
                    // repeated prefix keeps the switched size
                    op16_next = !cfg_op16_reg;
                end
                CLS_PREFIX:
                begin
                end
                CLS_IMM1:
                begin
                    skip_en = 1'b1;
                    skip_n  = 4'd1;
                end
                CLS_IMMV:
                begin
                    skip_en = 1'b1;
                    skip_n  = {1'b0, sz};
                end
                CLS_IMM2V:
                begin
                    skip_en = 1'b1;
                    skip_n  = 4'd2 + {1'b0, sz};
                end
                CLS_MRM_IMM1:
                begin
                    pend_imm_next = 3'd1;
                    phase_next    = PH_MODRM;
                end
                CLS_MRM_IMMV:
                begin
                    pend_imm_next = sz;
                    phase_next    = PH_MODRM;
                end
                CLS_MRM:
                begin
                    pend_imm_next = 3'd0;
                    phase_next    = PH_MODRM;
                end
                CLS_IMM2:
                begin
                    skip_en = 1'b1;
                    skip_n  = 4'd2;
                end
                CLS_IMM3:
                begin
                    skip_en = 1'b1;
                    skip_n  = 4'd3;
                end
                CLS_TEST:
                begin
                    low_bit_next  = b[0];
                    pend_imm_next = 3'd0;
                    phase_next    = PH_TEST;
                end
                CLS_ESCAPE:
                begin
                    phase_next = PH_ESC;
                end
                default:
                begin
                    // plain opcode, also unused class codes
                    done = 1'b1;
                end
            endcase
        end

        if (skip_en)
        begin
            if (skip_n == 4'd0)
            begin
                done = 1'b1;
            end
            else
            begin
                bytes_rem_next = skip_n;
                phase_next     = PH_TAIL;
            end
        end

        over = !done && (byte_count_next >= 4'(MAX_INSTR_LEN));
        emit = done || over;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_op16_reg   <= 1'b0;
            in_valid_reg   <= 1'b0;
            len_valid_reg  <= 1'b0;
            phase_reg      <= PH_OPC;
            byte_count_reg <= 4'd0;
            bytes_rem_reg  <= 4'd0;
            pend_imm_reg   <= 3'd0;
            op16_reg       <= 1'b0;
            esc_seen_reg   <= 1'b0;
            low_bit_reg    <= 1'b0;
            mod_reg        <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_op16_reg <= cfg_data;
            end
            if (code_ready)
            begin
                in_valid_reg <= code_valid;
            end
            if (process && emit)
            begin
                len_valid_reg <= 1'b1;
            end
            else if (len_ready)
            begin
                len_valid_reg <= 1'b0;
            end
            if (process)
            begin
                phase_reg      <= phase_next;
                byte_count_reg <= emit ? 4'd0 : byte_count_next;
                bytes_rem_reg  <= bytes_rem_next;
                pend_imm_reg   <= pend_imm_next;
                op16_reg       <= op16_next;
                esc_seen_reg   <= esc_seen_next;
                low_bit_reg    <= low_bit_next;
                mod_reg        <= mod_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_ready && code_valid)
        begin
            in_word_reg <= code_word;
        end
        if (process && emit)
        begin
            len_word_reg.instr_length <= byte_count_next;
            len_word_reg.two_byte_map <= esc_seen_next;
            len_word_reg.over_length  <= over;
        end
    end

`ifndef SYNTH
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        len_valid_reg |-> len_word_reg.instr_length != 4'd0)
        else $error("zero instruction length emitted");

    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        len_valid_reg && len_word_reg.over_length |->
            len_word_reg.instr_length == 4'(MAX_INSTR_LEN))
        else $error("over-length word without full length");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg != 4'(MAX_INSTR_LEN))
        else $error("byte count reached limit without a result");

    a_tail_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TAIL && byte_count_reg != 4'd0 |-> bytes_rem_reg != 4'd0)
        else $error("tail phase with nothing left to skip");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !code_ready |-> in_valid_reg && len_valid_reg && !len_ready)
        else $error("input stalled without a blocked result");
`endif

endmodule
